// ----- hdl/pks24_pkg.sv -----
// shared types, constants and round function for the 24-bit present key schedule
`timescale 1ns / 1ps
package pks24_pkg;

  localparam int KEY_W   = 24;
  localparam int REG_W   = 80;
  localparam int HIGH_W  = 16;
  localparam int LOW_W   = 64;
  localparam int ROUND_W = 5;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [REG_W-1:0]   keyreg_t;
  typedef logic [ROUND_W-1:0] round_t;

  // queue head as seen by the round engine
  typedef struct packed {
    logic valid;
    key_t key;
  } qhead_t;

  typedef logic [3:0] nibble_t;
  localparam nibble_t SBOX [16] = '{
    4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
    4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // master key sits in bits 79..56, rest cleared
  function automatic keyreg_t initial_reg(key_t key);
    keyreg_t r;
    r = {key, {(REG_W-KEY_W){1'b0}}};
    return r;
  endfunction

  // one key update: rotate left 61, s-box top nibble, round number into 19..15
  function automatic keyreg_t key_round(keyreg_t k, round_t rnd);
    keyreg_t r;
    r = {k[18:0], k[79:19]};
    r[79:76] = SBOX[r[79:76]];
    r[19:15] = r[19:15] ^ rnd;
    return r;
  endfunction

endpackage

// ----- hdl/pks24_front.sv -----
// input side: accepts master keys into a two-entry queue
`timescale 1ns / 1ps
module pks24_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pks24_pkg::key_t in_master_key,
  output pks24_pkg::qhead_t head,
  input  logic            pop
);
  import pks24_pkg::*;

  key_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       do_pop;

  assign in_ready   = (count_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.key   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_master_key;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid) else $error("pop from empty queue");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ----- hdl/pks24_engine.sv -----
// round engine: expands one master key into the round keys, one per cycle unless out_ready stalls
`timescale 1ns / 1ps
module pks24_engine #(
  parameter int ROUND_COUNT = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pks24_pkg::qhead_t       head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pks24_pkg::round_t       out_round_number,
  output pks24_pkg::keyreg_t      out_reg,
  output logic                    out_last_key
);
  import pks24_pkg::*;

  localparam round_t LAST_RND = ROUND_W'(ROUND_COUNT);

  logic    busy_r, busy_nxt;
  keyreg_t state_r, state_nxt;
  round_t  rnd_r, rnd_nxt;
  logic    ovalid_r, ovalid_nxt;
  logic    olast_r, olast_nxt;
  keyreg_t oreg_r, oreg_nxt;
  round_t  ornd_r, ornd_nxt;
  logic    out_free;
  logic    load;
  logic    step;
  round_t  rnd_inc;
  keyreg_t next_reg;

  assign out_free = !ovalid_r || out_ready;
  assign load     = !busy_r && head.valid && out_free;
  assign step     = busy_r && out_free;
  assign pop      = load;
  assign rnd_inc  = rnd_r + 1'b1;
  assign next_reg = key_round(state_r, rnd_inc);

  always_comb begin
    busy_nxt   = busy_r;
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    ovalid_nxt = ovalid_r && !out_ready;
    oreg_nxt   = oreg_r;
    ornd_nxt   = ornd_r;
    olast_nxt  = olast_r;
    if (load) begin
      busy_nxt   = 1'b1;
      state_nxt  = initial_reg(head.key);
      rnd_nxt    = '0;
      ovalid_nxt = 1'b1;
      oreg_nxt   = initial_reg(head.key);
      ornd_nxt   = '0;
      olast_nxt  = 1'b0;
    end else if (step) begin
      state_nxt  = next_reg;
      rnd_nxt    = rnd_inc;
      ovalid_nxt = 1'b1;
      oreg_nxt   = next_reg;
      ornd_nxt   = rnd_inc;
      olast_nxt  = (rnd_inc == LAST_RND);
      busy_nxt   = (rnd_inc != LAST_RND);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    rnd_r   <= rnd_nxt;
    oreg_r  <= oreg_nxt;
    ornd_r  <= ornd_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_reg          = oreg_r;
  assign out_round_number = ornd_r;
  assign out_last_key     = olast_r;

`ifndef SYNTHESIS
  a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rnd_r < LAST_RND)) else $error("round counter past last round");
  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && olast_r) |-> (ornd_r == LAST_RND)) else $error("last flag on wrong round");
  a_load_round0: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (ovalid_r && ornd_r == '0 && busy_r)) else $error("load did not emit round 0");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !busy_r) else $error("queue popped while busy");
`endif

endmodule

// ----- hdl/present_key_schedule_24_core.sv -----
// top level of the 24-bit present key schedule: key queue plus round engine
`timescale 1ns / 1ps
//
// channel  | ports                                     | dir | beat
// ---------+-------------------------------------------+-----+------------------------
// input    | in_valid, in_ready, in_master_key         | in  | one master key
// result   | out_valid, out_ready, out_round_number,   | out | one round key with the
//          | out_round_key, out_register_high/low,     |     | full 80-bit register
//          | out_last_key                              |     |
//
// each master key gives ROUND_COUNT+1 result beats, one per cycle while out_ready
// stays high; the single round engine feeding the result register sets that rate
// a two-entry key queue in front takes new keys while the engine works
// first result passes through the key queue and the result register after the key beat when the engine is free
// rst_n is synchronous, active low; it empties the queue and the result register
// a stall on out_ready holds the engine; the queue fills and then drops in_ready
module present_key_schedule_24_core #(
  parameter int ROUND_COUNT = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [23:0]                in_master_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [4:0]                 out_round_number,
  output logic [23:0]                out_round_key,
  output logic [15:0]                out_register_high,
  output logic [63:0]                out_register_low,
  output logic                       out_last_key
);
  import pks24_pkg::*;

  qhead_t  head;      // front queue head toward the engine
  logic    pop;       // engine takes the head key
  keyreg_t out_reg;   // full 80-bit key register of the current beat

  pks24_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_master_key (in_master_key),
    .head          (head),
    .pop           (pop)
  );

  pks24_engine #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_round_number (out_round_number),
    .out_reg          (out_reg),
    .out_last_key     (out_last_key)
  );

  // round key is register bits 39..16
  assign out_round_key     = out_reg[39:16];
  assign out_register_high = out_reg[79:64];
  assign out_register_low  = out_reg[63:0];

endmodule

// ----- tb/present_key_schedule_24_checker.sv -----
// checker for the 24-bit present key schedule: predicts round key beats and compares them
`timescale 1ns / 1ps
module present_key_schedule_24_checker #(
  parameter int ROUND_COUNT = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  pks24_pkg::key_t   in_master_key,
  input  logic              out_valid,
  input  logic              out_ready,
  input  pks24_pkg::round_t out_round_number,
  input  logic [23:0]       out_round_key,
  input  logic [15:0]       out_register_high,
  input  logic [63:0]       out_register_low,
  input  logic              out_last_key,
  output int                mismatch_count,
  output int                beats_pending
);
  import pks24_pkg::*;

  localparam logic [3:0] KEY_SBOX [16] = '{
    4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
    4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  typedef struct packed {
    round_t      rnd;
    logic [23:0] round_key;
    logic [15:0] reg_high;
    logic [63:0] reg_low;
    logic        last;
  } round_key_beat_t;

  round_key_beat_t round_keys_due[$];

  // all ROUND_COUNT+1 beats that one master key produces
  function automatic void schedule_master_key(key_t key);
    keyreg_t         kr;
    round_key_beat_t beat;
    kr = {key, {(REG_W-KEY_W){1'b0}}};
    for (int r = 0; r <= ROUND_COUNT; r++) begin
      if (r > 0) begin
        kr = {kr[18:0], kr[79:19]};
        kr[79:76] = KEY_SBOX[kr[79:76]];
        kr[19:15] = kr[19:15] ^ round_t'(r);
      end
      beat.rnd       = round_t'(r);
      beat.round_key = kr[39:16];
      beat.reg_high  = kr[79:64];
      beat.reg_low   = kr[63:0];
      beat.last      = (r == ROUND_COUNT);
      round_keys_due.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    round_key_beat_t want;
    if (!rst_n) begin
      round_keys_due.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && in_ready) schedule_master_key(in_master_key);
      if (out_valid && out_ready) begin
        if (round_keys_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with none expected: rnd=%0d key=%h reg=%h_%h last=%b",
                     $realtime, out_round_number, out_round_key, out_register_high,
                     out_register_low, out_last_key);
        end else begin
          want = round_keys_due.pop_front();
          if (out_round_number !== want.rnd || out_round_key !== want.round_key ||
              out_register_high !== want.reg_high || out_register_low !== want.reg_low ||
              out_last_key !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch expected rnd=%0d key=%h reg=%h_%h last=%b",
                       $realtime, want.rnd, want.round_key, want.reg_high, want.reg_low,
                       want.last);
              $display("%0t:            actual rnd=%0d key=%h reg=%h_%h last=%b",
                       $realtime, out_round_number, out_round_key, out_register_high,
                       out_register_low, out_last_key);
            end
          end
        end
      end
    end
    beats_pending = round_keys_due.size();
  end

endmodule

// ----- tb/tb_present_key_schedule_24_core.sv -----
// testbench top for the 24-bit present key schedule: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_present_key_schedule_24_core;
  import pks24_pkg::*;

  localparam int ROUND_COUNT  = 10;
  // worst case is far below this: ~215 keys, 11 beats each, occasional long stalls
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_KEYS  = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  key_t        in_master_key;
  logic        out_valid;
  logic        out_ready;
  round_t      out_round_number;
  logic [23:0] out_round_key;
  logic [15:0] out_register_high;
  logic [63:0] out_register_low;
  logic        out_last_key;

  int mismatch_count;
  int beats_pending;
  int cycle_count = 0;
  // when set, neither side idles: back-to-back keys and a sink that never stalls
  bit steady = 1'b1;

  always #6 clk = ~clk;

  present_key_schedule_24_core #(
    .ROUND_COUNT(ROUND_COUNT)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_master_key    (in_master_key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_round_number (out_round_number),
    .out_round_key    (out_round_key),
    .out_register_high(out_register_high),
    .out_register_low (out_register_low),
    .out_last_key     (out_last_key)
  );

  present_key_schedule_24_checker #(
    .ROUND_COUNT(ROUND_COUNT)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_master_key    (in_master_key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_round_number (out_round_number),
    .out_round_key    (out_round_key),
    .out_register_high(out_register_high),
    .out_register_low (out_register_low),
    .out_last_key     (out_last_key),
    .mismatch_count   (mismatch_count),
    .beats_pending    (beats_pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // called at a falling edge, returns at the falling edge after the key beat;
  // in_valid stays high so the next key can follow without a bubble
  task automatic send_key(input key_t key);
    int gap;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_master_key <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and hold the sender until every expected round key has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (beats_pending != 0) @(negedge clk);
  endtask

  // random master key: mostly full random, some one-hot and one-cold patterns
  function automatic key_t random_key();
    key_t one_hot;
    one_hot = key_t'(1) << $urandom_range(0, KEY_W-1);
    case ($urandom_range(0, 7))
      0:       return one_hot;
      1:       return ~one_hot;
      default: return key_t'($urandom());
    endcase
  endfunction

  // result sink: random stalls unless in a steady stretch
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    key_t directed_keys[$];
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_master_key = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, alternating patterns and sbox-sensitive top nibbles
    directed_keys = '{24'h000000, 24'hffffff, 24'h000001, 24'h800000, 24'h555555,
                      24'haaaaaa, 24'h0f0f0f, 24'hf0f0f0, 24'h123456, 24'hfedcba,
                      24'h100000, 24'h700000, 24'hc00000, 24'h00ffff, 24'hffff00};
    // first keys back to back with a sink that never stalls
    foreach (directed_keys[i]) begin
      if (i == 6) steady = 1'b0;
      send_key(directed_keys[i]);
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_KEYS; n++) begin
      // alternate stretches with and without idling
      if (n % 40 == 0) steady = (n % 80 == 40);
      // sender occasionally waits for the pipeline to empty
      if (n % 50 == 25) hold_until_drained();
      send_key(random_key());
    end

    hold_until_drained();
    repeat (2 * (ROUND_COUNT + 1) + 10) @(negedge clk);
    if (mismatch_count == 0 && beats_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/pks24_pkg.sv
hdl/pks24_front.sv
hdl/pks24_engine.sv
hdl/present_key_schedule_24_core.sv
tb/present_key_schedule_24_checker.sv
tb/tb_present_key_schedule_24_core.sv
